// ----- hdl/sfsc_pkg.sv -----
package sfsc_pkg;

	localparam int DEF_MAX_WIDTH     = 64;
	localparam int DEF_MAX_HEIGHT    = 64;
	localparam int DEF_MAX_FOOTPRINT = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int COUNT_W    = 13;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH      = 2'd0,
		REG_MAP_HEIGHT     = 2'd1,
		REG_FOOTPRINT_SIZE = 2'd2,
		REG_UNUSED         = 2'd3
	} cfg_reg_t;

	localparam logic [6:0] MAP_WIDTH_RST      = 7'd64;
	localparam logic [6:0] MAP_HEIGHT_RST     = 7'd64;
	localparam logic [4:0] FOOTPRINT_SIZE_RST = 5'd1;

endpackage

// ----- hdl/square_footprint_site_counter_core.sv -----
// Square footprint site counter.
// s_* channel: one map tile per beat, row-major; s_tdata[0] buildable,
// s_tdata[1] in_region, s_tlast marks the final tile and starts the count.
// m_* channel: one beat per map, m_tdata[12:0] = number of anchor tiles whose
// footprint_size square (toroidal wrap) is fully usable.
// cfg_* channel: register writes (0 map_width, 1 map_height, 2 footprint_size),
// always ready; write only while the block is idle.
// Tiles load at one per cycle. After the last tile two passes run, each going
// twice around every row (pass 1) or column (pass 2) through one shared
// carry/compare unit, one tile per cycle, set by the single read port of the
// tile and run memories. s_tready is low during the passes and until the
// result sits in the output register. A finished result waits in that register
// while the next map loads; if it is still unread when the next count ends, the
// block holds there. Reset clears control state, the load address and the
// count; registers return to 64, 64, 1. Map memories are not cleared.
module square_footprint_site_counter_core
	import sfsc_pkg::*;
#(
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
	parameter int MAX_FOOTPRINT = DEF_MAX_FOOTPRINT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [0] buildable, [1] in_region, rest zero
	input  logic                  s_tlast,  // last_tile
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [12:0] site_count, rest zero
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_FOOTPRINT + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_P1,
		ST_P1_DRAIN,
		ST_P2,
		ST_P2_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic          vld;
		logic          pass2;
		logic          lap;
		logic          first;
		logic [AW-1:0] addr;
	} pipe_t;

	state_t             state_q;
	logic [6:0]         map_width_q;
	logic [6:0]         map_height_q;
	logic [4:0]         footprint_q;
	logic [AW-1:0]      load_q;
	logic [AW-1:0]      base_q;
	logic [AW-1:0]      last_base_q;
	logic [XW-1:0]      x_q;
	logic [YW-1:0]      y_q;
	logic               lap_q;
	logic [RW-1:0]      carry_q;
	logic               zero_q;
	logic [COUNT_W-1:0] total_q;
	logic               m_tvalid_q;
	logic [COUNT_W-1:0] m_count_q;
	pipe_t              pipe_s1;
	logic               usable_rd_s1;
	logic [RW-1:0]      run_rd_s1;

	logic               usable_mem [CELLS];
	logic [RW-1:0]      run_mem [CELLS];

	logic [WW-1:0]      w_c;
	logic [HW-1:0]      h_c;
	logic [RW-1:0]      s_c;
	logic [XW-1:0]      x_last;
	logic [YW-1:0]      y_last;
	logic [AW-1:0]      rd_addr;
	logic               tile_acc;
	logic               ok;
	logic [RW-1:0]      carry_base;
	logic               zero_base;
	logic [RW-1:0]      carry_next;
	logic               zero_next;
	logic [RW-1:0]      run_val;
	logic               anchor;

	always_comb begin
		if (map_width_q == 7'd0)
			w_c = WW'(1);
		else if ({2'b00, map_width_q} > 9'(MAX_WIDTH))
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(map_width_q);
		if (map_height_q == 7'd0)
			h_c = HW'(1);
		else if ({2'b00, map_height_q} > 9'(MAX_HEIGHT))
			h_c = HW'(MAX_HEIGHT);
		else
			h_c = HW'(map_height_q);
		if (footprint_q == 5'd0)
			s_c = RW'(1);
		else if ({2'b00, footprint_q} > 7'(MAX_FOOTPRINT))
			s_c = RW'(MAX_FOOTPRINT);
		else
			s_c = RW'(footprint_q);
	end

	assign x_last   = XW'(w_c - WW'(1));
	assign y_last   = YW'(h_c - HW'(1));
	assign rd_addr  = base_q + AW'(x_q);
	assign s_tready = (state_q == ST_LOAD);
	assign tile_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - COUNT_W){1'b0}}, m_count_q};

	// shared capped-run unit: horizontal runs in pass 1, vertical runs in pass 2
	always_comb begin
		ok         = pipe_s1.pass2 ? (run_rd_s1 >= s_c) : usable_rd_s1;
		carry_base = pipe_s1.first ? '0 : carry_q;
		zero_base  = pipe_s1.first ? 1'b0 : zero_q;
		if (!ok)
			carry_next = '0;
		else if (carry_base >= s_c)
			carry_next = s_c;
		else
			carry_next = carry_base + RW'(1);
		zero_next = zero_base | ~ok;
		run_val   = zero_next ? carry_next : s_c;
		anchor    = pipe_s1.vld && pipe_s1.pass2 && pipe_s1.lap && (run_val >= s_c);
	end

	always_ff @(posedge clk) begin
		if (tile_acc)
			usable_mem[load_q] <= s_tdata[0] & s_tdata[1];
		usable_rd_s1 <= usable_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pipe_s1.vld && !pipe_s1.pass2 && pipe_s1.lap)
			run_mem[pipe_s1.addr] <= run_val;
		run_rd_s1 <= run_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
			footprint_q  <= FOOTPRINT_SIZE_RST;
			load_q       <= '0;
			base_q       <= '0;
			last_base_q  <= '0;
			x_q          <= '0;
			y_q          <= '0;
			lap_q        <= 1'b0;
			carry_q      <= '0;
			zero_q       <= 1'b0;
			total_q      <= '0;
			m_tvalid_q   <= 1'b0;
			m_count_q    <= '0;
			pipe_s1      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_MAP_WIDTH:      map_width_q  <= cfg_data;
					REG_MAP_HEIGHT:     map_height_q <= cfg_data;
					REG_FOOTPRINT_SIZE: footprint_q  <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;

			if (pipe_s1.vld) begin
				carry_q <= carry_next;
				zero_q  <= zero_next;
				if (anchor)
					total_q <= total_q + COUNT_W'(1);
			end

			if (state_q != ST_P1 && state_q != ST_P2)
				pipe_s1.vld <= 1'b0;

			unique case (state_q)
				ST_LOAD: begin
					if (tile_acc) begin
						if (s_tlast) begin
							load_q  <= '0;
							base_q  <= '0;
							x_q     <= x_last;
							y_q     <= '0;
							lap_q   <= 1'b0;
							state_q <= ST_P1;
						end else if (load_q == AW'(CELLS - 1)) begin
							load_q <= '0;
						end else begin
							load_q <= load_q + AW'(1);
						end
					end
				end
				ST_P1: begin
					pipe_s1.vld   <= 1'b1;
					pipe_s1.pass2 <= 1'b0;
					pipe_s1.lap   <= lap_q;
					pipe_s1.first <= !lap_q && (x_q == x_last);
					pipe_s1.addr  <= rd_addr;
					if (x_q != '0) begin
						x_q <= x_q - XW'(1);
					end else if (!lap_q) begin
						lap_q <= 1'b1;
						x_q   <= x_last;
					end else begin
						lap_q <= 1'b0;
						x_q   <= x_last;
						if (y_q == y_last) begin
							last_base_q <= base_q;
							state_q     <= ST_P1_DRAIN;
						end else begin
							y_q    <= y_q + YW'(1);
							base_q <= base_q + AW'(w_c);
						end
					end
				end
				ST_P1_DRAIN: begin
					base_q  <= last_base_q;
					x_q     <= '0;
					y_q     <= y_last;
					lap_q   <= 1'b0;
					total_q <= '0;
					state_q <= ST_P2;
				end
				ST_P2: begin
					pipe_s1.vld   <= 1'b1;
					pipe_s1.pass2 <= 1'b1;
					pipe_s1.lap   <= lap_q;
					pipe_s1.first <= !lap_q && (y_q == y_last);
					pipe_s1.addr  <= rd_addr;
					if (y_q != '0) begin
						y_q    <= y_q - YW'(1);
						base_q <= base_q - AW'(w_c);
					end else begin
						base_q <= last_base_q;
						y_q    <= y_last;
						if (!lap_q) begin
							lap_q <= 1'b1;
						end else begin
							lap_q <= 1'b0;
							if (x_q == x_last)
								state_q <= ST_P2_DRAIN;
							else
								x_q <= x_q + XW'(1);
						end
					end
				end
				ST_P2_DRAIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_count_q  <= total_q;
						state_q    <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// ----- hdl/sfsc_checker.sv -----
module sfsc_checker
	import sfsc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// last tile closes the input until the count is out
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after last tile");

	// a new result only appears at the end of a count
	a_result_after_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a count");

	// count fits in its field
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:COUNT_W] == '0)
		else $error("result padding not zero");

endmodule

bind square_footprint_site_counter_core sfsc_checker u_sfsc_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import sfsc_pkg::*;

	localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int N_DIR = 9;
	localparam int RX_HOLD = 1500;
	localparam int RAND_TILES = 830;
	localparam int RAND_MAPS = 20;
	localparam int CYCLE_LIMIT = 1500000;

	typedef enum logic [2:0] {
		PAT_ALL,
		PAT_NONE,
		PAT_BONLY,
		PAT_RONLY,
		PAT_ALT,
		PAT_RAND
	} pat_t;

	typedef struct packed {
		logic [6:0] width;
		logic [6:0] height;
		logic [6:0] fp;
		int         tiles;
		pat_t       pat;
		int         known;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [0] buildable, [1] in_region
	logic                  s_tlast = 1'b0;  // last_tile
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [12:0] site_count
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAP_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit          tile_usable [CELLS];
	bit          tile_written [CELLS];
	int unsigned load_addr = 0;
	logic [6:0]  reg_width = MAP_WIDTH_RST;
	logic [6:0]  reg_height = MAP_HEIGHT_RST;
	logic [4:0]  reg_fp = FOOTPRINT_SIZE_RST;

	int unsigned pending_counts [$];
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;
	dir_row_t    dir_rows [N_DIR];

	square_footprint_site_counter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned eff(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// horizontal capped runs with wrap, then vertical check over fp rows
	function automatic int unsigned count_sites();
		int unsigned w, h, fp, x, y, dy, len, total;
		bit fits;
		byte unsigned runs [CELLS];
		w = eff(reg_width, DEF_MAX_WIDTH);
		h = eff(reg_height, DEF_MAX_HEIGHT);
		fp = eff(reg_fp, DEF_MAX_FOOTPRINT);
		total = 0;
		for (y = 0; y < h; y++)
			for (x = 0; x < w; x++) begin
				len = 0;
				while (len < fp && tile_usable[y * w + (x + len) % w])
					len++;
				runs[y * w + x] = 8'(len);
			end
		for (y = 0; y < h; y++)
			for (x = 0; x < w; x++) begin
				fits = 1'b1;
				for (dy = 0; dy < fp && fits; dy++)
					fits = runs[((y + dy) % h) * w + x] >= fp;
				if (fits)
					total++;
			end
		return total & ((1 << COUNT_W) - 1);
	endfunction

	function automatic bit all_written(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			if (!tile_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [6:0] pick_dim(bit allow_big);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 7'd0;
		if (r < 8 && allow_big)
			return 7'($urandom_range(65, 127));
		if (r < 10 && allow_big)
			return 7'd64;
		if (r < 25)
			return 7'($urandom_range(9, 16));
		return 7'($urandom_range(1, 8));
	endfunction

	function automatic logic [4:0] pick_fp();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 5'd0;
		if (r < 10)
			return 5'($urandom_range(17, 31));
		if (r < 25)
			return 5'($urandom_range(5, 16));
		return 5'($urandom_range(1, 4));
	endfunction

	task automatic cfg_write(cfg_reg_t idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_MAP_WIDTH: reg_width = val;
			REG_MAP_HEIGHT: reg_height = val;
			REG_FOOTPRINT_SIZE: reg_fp = val[4:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_counts.size() != 0);
	endtask

	task automatic send_tile(bit bld, bit rgn, bit last, int known);
		int unsigned gap;
		int unsigned expected;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_DATA_W - 2){1'b0}}, rgn, bld};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tile_usable[load_addr] = bld & rgn;
		tile_written[load_addr] = 1'b1;
		load_addr = (load_addr + 1) % CELLS;
		if (last) begin
			if (known < 0)
				expected = count_sites();
			else
				expected = unsigned'(known);
			pending_counts = {pending_counts, expected};
			load_addr = 0;
		end
	endtask

	task automatic send_map(int unsigned n, pat_t pat, int unsigned dens, int known);
		bit ok, bld, rgn;
		int unsigned k;
		for (int unsigned i = 0; i < n; i++) begin
			case (pat)
				PAT_ALL: ok = 1'b1;
				PAT_ALT: ok = (i % 2 == 0);
				PAT_RAND: ok = ($urandom_range(0, 15) < dens);
				default: ok = 1'b0;
			endcase
			if (ok) begin
				bld = 1'b1;
				rgn = 1'b1;
			end else begin
				k = $urandom_range(0, 2);
				bld = (k == 1);
				rgn = (k == 2);
			end
			if (pat == PAT_BONLY) begin
				bld = 1'b1;
				rgn = 1'b0;
			end else if (pat == PAT_RONLY) begin
				bld = 1'b0;
				rgn = 1'b1;
			end else if (pat == PAT_NONE) begin
				bld = 1'b0;
				rgn = 1'b0;
			end
			send_tile(bld, rgn, i == n - 1, known);
		end
	endtask

	// result side; one long hold once the directed maps are through
	initial begin
		int unsigned stall;
		int unsigned want;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 5);
			if (results_seen == N_DIR && !held) begin
				stall = RX_HOLD;
				held = 1'b1;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			results_seen++;
			if (pending_counts.size() == 0) begin
				$error("site_count: no result pending, actual %0d", m_tdata[COUNT_W-1:0]);
				mismatches++;
			end else begin
				want = pending_counts.pop_front();
				if (m_tdata[COUNT_W-1:0] !== want[COUNT_W-1:0]) begin
					$error("site_count mismatch: expected %0d, actual %0d",
						want, m_tdata[COUNT_W-1:0]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[square_footprint_site_counter_core] ERROR");
		$finish;
	end

	initial begin
		int unsigned n, k, dens, rand_tiles, rand_maps;
		dir_rows = '{
			'{7'd1, 7'd1, 7'd1,  1, PAT_ALL,   1},
			'{7'd1, 7'd1, 7'd0,  1, PAT_NONE,  0},
			'{7'd1, 7'd1, 7'd16, 1, PAT_ALL,   1},
			'{7'd2, 7'd2, 7'd31, 4, PAT_ALL,   4},
			'{7'd2, 7'd2, 7'd1,  4, PAT_BONLY, 0},
			'{7'd2, 7'd2, 7'd1,  4, PAT_RONLY, 0},
			'{7'd2, 7'd2, 7'd2,  1, PAT_NONE,  0},   // short map
			'{7'd0, 7'd0, 7'd1,  2, PAT_ALT,   1},   // zero dims, extra tile
			'{7'd3, 7'd2, 7'd2,  6, PAT_RAND,  -1}
		};
		rand_tiles = 0;
		rand_maps = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			wait_idle();
			cfg_write(REG_MAP_WIDTH, dir_rows[i].width);
			cfg_write(REG_MAP_HEIGHT, dir_rows[i].height);
			cfg_write(REG_FOOTPRINT_SIZE, dir_rows[i].fp);
			send_map(dir_rows[i].tiles, dir_rows[i].pat, 8, dir_rows[i].known);
		end

		// back-to-back maps while the result side holds off
		wait_idle();
		cfg_write(REG_MAP_WIDTH, 7'd3);
		cfg_write(REG_MAP_HEIGHT, 7'd3);
		cfg_write(REG_FOOTPRINT_SIZE, 7'd2);
		repeat (4) send_map(9, PAT_RAND, 14, -1);

		// wide map, saturated width and footprint
		wait_idle();
		cfg_write(REG_MAP_WIDTH, 7'd127);
		cfg_write(REG_MAP_HEIGHT, 7'd4);
		cfg_write(REG_FOOTPRINT_SIZE, 7'h7F);
		send_map(DEF_MAX_WIDTH * 4, PAT_ALL, 16, -1);

		wait_idle();
		cfg_write(REG_UNUSED, 7'($urandom_range(0, 127)));
		cfg_write(REG_MAP_WIDTH, 7'd4);
		cfg_write(REG_MAP_HEIGHT, 7'd4);
		cfg_write(REG_FOOTPRINT_SIZE, 7'd2);

		while (rand_tiles < RAND_TILES || rand_maps < RAND_MAPS) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 3) begin
				wait_idle();
				if ($urandom_range(0, 1))
					cfg_write(REG_MAP_WIDTH,
						pick_dim(eff(reg_height, DEF_MAX_HEIGHT) <= 4));
				if ($urandom_range(0, 1))
					cfg_write(REG_MAP_HEIGHT,
						pick_dim(eff(reg_width, DEF_MAX_WIDTH) <= 4));
				if ($urandom_range(0, 1))
					cfg_write(REG_FOOTPRINT_SIZE, {2'($urandom_range(0, 3)), pick_fp()});
				if ($urandom_range(0, 15) == 0)
					cfg_write(REG_UNUSED, 7'($urandom_range(0, 127)));
			end
			n = eff(reg_width, DEF_MAX_WIDTH) * eff(reg_height, DEF_MAX_HEIGHT);
			k = $urandom_range(0, 9);
			if (k == 0 && n > 1 && all_written(n))
				n = $urandom_range(1, n - 1);
			else if (k == 1)
				n += $urandom_range(1, 4);
			case ($urandom_range(0, 4))
				0: dens = 16;
				1: dens = 15;
				2: dens = 12;
				3: dens = 8;
				default: dens = 2;
			endcase
			send_map(n, PAT_RAND, dens, -1);
			rand_tiles += n;
			rand_maps++;
		end

		quiet = 1'b0;
		wait_idle();
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("[square_footprint_site_counter_core] OK");
		else
			$display("[square_footprint_site_counter_core] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/sfsc_pkg.sv
hdl/square_footprint_site_counter_core.sv
hdl/sfsc_checker.sv
verif/testbench.sv
